// ----- rtl/core/prime_field_inverse_assert.svh -----
// Assertion macros used by the checker file of the field inverse block.
`ifndef PRIME_FIELD_INVERSE_ASSERT_SVH
`define PRIME_FIELD_INVERSE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define PFINV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset cycles included.
`define PFINV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/pfinv_pkg.sv -----
// Types and constants of the prime field inverse pipeline.
package pfinv_pkg;

  localparam int unsigned FIELD_W = 30;
  localparam int unsigned LAZY_W  = 31;
  localparam int unsigned PROD_W  = 62;
  localparam int unsigned MONT_W  = 32;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [LAZY_W-1:0]  lazy_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [MONT_W-1:0]  mont_t;

  // Prime p = 119 * 2^23 + 1
  localparam field_t      MODULUS   = 30'd998244353;
  localparam logic [6:0]  MOD_HI    = 7'd119;
  localparam int unsigned MOD_SHIFT = 23;
  localparam int unsigned QLO_W     = MONT_W - MOD_SHIFT;

  // Montgomery radix R = 2^32: R mod p and R^2 mod p
  localparam field_t R_MOD  = 30'd301989884;
  localparam field_t R2_MOD = 30'd932051910;

  // Fermat exponent p - 2
  localparam field_t EXPONENT = 30'd998244351;

  // Pipeline shape
  localparam int unsigned NUM_ROUNDS = FIELD_W;
  localparam int unsigned MM_LAT     = 3;
  localparam int unsigned PIPE_DEPTH = MM_LAT * (NUM_ROUNDS + 2);

endpackage

// ----- rtl/core/pfinv_mont_mul.sv -----
// Three-stage Montgomery multiplier for p = 119 * 2^23 + 1, lazy range [0, 2p).
module pfinv_mont_mul (
  input  logic             clk,
  input  logic             en,
  input  pfinv_pkg::lazy_t a,
  input  pfinv_pkg::lazy_t b,
  output pfinv_pkg::lazy_t r
);
  import pfinv_pkg::*;

  prod_t              t1_r;
  prod_t              t2_r;
  mont_t              m_r;
  mont_t              m_nxt;
  lazy_t              r_r;
  logic [15:0]        q_full;
  logic [MONT_W+6:0]  m119;
  logic [63:0]        sum;

  // Stage 2: m = T * (-1/p) mod 2^32, where -1/p = 119 * 2^23 - 1
  always_comb begin
    q_full = 16'(t1_r[QLO_W-1:0]) * 16'(MOD_HI);
    m_nxt  = {q_full[QLO_W-1:0], {MOD_SHIFT{1'b0}}} - t1_r[MONT_W-1:0];
  end

  // Stage 3: (T + m * p) / 2^32, with m * p = (m * 119) << 23 + m
  always_comb begin
    m119 = (MONT_W+7)'(m_r) * (MONT_W+7)'(MOD_HI);
    sum  = 64'(t2_r) + 64'({m119, {MOD_SHIFT{1'b0}}}) + 64'(m_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= PROD_W'(a) * PROD_W'(b);
      t2_r <= t1_r;
      m_r  <= m_nxt;
      r_r  <= sum[MONT_W+LAZY_W-1:MONT_W];
    end
  end

  assign r = r_r;

endmodule

// ----- rtl/core/pfinv_delay.sv -----
// Enabled shift line that keeps a bypassed operand aligned with a multiplier.
module pfinv_delay #(
  parameter int unsigned W     = 31,
  parameter int unsigned DEPTH = 3
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

// ----- rtl/core/prime_field_inverse.sv -----
// Top level: fully pipelined inverse modulo 998244353 by Fermat exponentiation.
//
// Input channel in_valid / in_stall / in_value carries one 30-bit residue per item;
// result channel out_valid / out_stall / out_inverse returns value^(p-2) mod p.
// Zero (and p itself) gives zero. Unreduced inputs up to 2^30-1 are accepted.
// One item may enter every cycle while in_stall is low, and one result may leave every cycle while out_stall is low.
// The path from the accepting edge to out_valid holds 32 Montgomery
// multiplications of 3 stages each (entry conversion, 30 square-and-multiply
// rounds, exit conversion), the first stage loading at the accepting edge,
// then the output register.
// Each round but the last squares the running base; each multiplies it into the
// product where the exponent bit is set. Both run side by side in their own units.
// A two-entry output buffer lets the pipeline keep moving while the receiver
// holds one result; in_stall rises only when both entries are full, and the
// whole pipeline freezes with it. Nothing is dropped or repeated.
// Synchronous reset clears all valid bits; no item is in flight afterwards.
module prime_field_inverse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfinv_pkg::field_t in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output pfinv_pkg::field_t out_inverse
);
  import pfinv_pkg::*;

  logic   en;
  logic   push;
  logic   vld_r [PIPE_DEPTH];
  lazy_t  acc_w [NUM_ROUNDS+1];
  lazy_t  base_w [NUM_ROUNDS];
  lazy_t  res_w;
  field_t fin_w;

  logic   out_valid_r, out_valid_nxt;
  field_t out_inverse_r, out_inverse_nxt;
  logic   skid_valid_r, skid_valid_nxt;
  field_t skid_inverse_r, skid_inverse_nxt;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign push     = en && vld_r[PIPE_DEPTH-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < PIPE_DEPTH; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int j = 1; j < PIPE_DEPTH; j++) begin
        vld_r[j] <= vld_r[j-1];
      end
    end
  end

  // Into Montgomery form: base = v * R mod p
  pfinv_mont_mul u_enter (
    .clk (clk),
    .en  (en),
    .a   (lazy_t'(in_value)),
    .b   (lazy_t'(R2_MOD)),
    .r   (base_w[0])
  );

  // Running product starts at one, i.e. R mod p
  assign acc_w[0] = lazy_t'(R_MOD);

  // Square-and-multiply rounds, low exponent bit first
  for (genvar gi = 0; gi < NUM_ROUNDS; gi++) begin : g_round
    if (EXPONENT[gi]) begin : g_mul
      pfinv_mont_mul u_mul (
        .clk (clk),
        .en  (en),
        .a   (acc_w[gi]),
        .b   (base_w[gi]),
        .r   (acc_w[gi+1])
      );
    end else begin : g_pass
      pfinv_delay #(.W(LAZY_W), .DEPTH(MM_LAT)) u_pass (
        .clk (clk),
        .en  (en),
        .d   (acc_w[gi]),
        .q   (acc_w[gi+1])
      );
    end
    if (gi < NUM_ROUNDS - 1) begin : g_sqr
      pfinv_mont_mul u_sqr (
        .clk (clk),
        .en  (en),
        .a   (base_w[gi]),
        .b   (base_w[gi]),
        .r   (base_w[gi+1])
      );
    end
  end

  // Out of Montgomery form; result lands in [0, p]
  pfinv_mont_mul u_exit (
    .clk (clk),
    .en  (en),
    .a   (acc_w[NUM_ROUNDS]),
    .b   (lazy_t'(1)),
    .r   (res_w)
  );

  // Final correction to [0, p)
  always_comb begin
    if (res_w >= lazy_t'(MODULUS)) begin
      fin_w = field_t'(res_w - lazy_t'(MODULUS));
    end else begin
      fin_w = field_t'(res_w);
    end
  end

  // Output register plus skid entry
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_inverse_nxt  = out_inverse_r;
    skid_valid_nxt   = skid_valid_r;
    skid_inverse_nxt = skid_inverse_r;
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_inverse_nxt = skid_inverse_r;
        skid_valid_nxt  = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || !out_stall) begin
        out_valid_nxt   = 1'b1;
        out_inverse_nxt = fin_w;
      end else begin
        skid_valid_nxt   = 1'b1;
        skid_inverse_nxt = fin_w;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_inverse_r  <= out_inverse_nxt;
    skid_inverse_r <= skid_inverse_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_inverse = out_inverse_r;

endmodule

// ----- rtl/core/pfinv_checker.sv -----
// Port-level checker for the field inverse block and its bind.
`include "prime_field_inverse_assert.svh"

module pfinv_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input pfinv_pkg::field_t out_inverse
);
  import pfinv_pkg::*;

  // Held result stays put
  `PFINV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `PFINV_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_inverse), "stalled result changed")

  // Results are fully reduced
  `PFINV_ASSERT(a_out_range, out_valid |-> (out_inverse < MODULUS), "result not below the modulus")

  // Input backpressure only with a result waiting at the output
  `PFINV_ASSERT(a_stall_full, in_stall |-> out_valid, "input stalled with empty output")

  // Reset empties the output and releases the input
  `PFINV_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid && !in_stall, "reset left state behind")

endmodule

bind prime_field_inverse pfinv_checker u_pfinv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_inverse (out_inverse)
);
